>>> rtl/dnd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dnd_pkg;

    localparam int ADDR_W        = 9;
    localparam int MSG_BYTES_DEF = 512;
    localparam int MAX_HOPS_DEF  = 16;
    localparam int MAX_TEXT_DEF  = 256;
    localparam int POS_W         = 15;
    localparam int JOBQ_DEPTH    = 4;
    localparam int RESQ_DEPTH    = 2;

    localparam logic [7:0] DOT_CHAR = 8'h2E;
    localparam logic [1:0] PTR_TAG  = 2'b11;

    typedef enum logic {
        CMD_STORE  = 1'b0,
        CMD_DECODE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_HOPS  = 2'd2,
        ST_LONG  = 2'd3
    } t_status;

    typedef struct packed {
        logic        cmd;
        logic [8:0]  address;
        logic [7:0]  data_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0] text_chars;
        logic [2:0]  char_count;
        logic        last;
        t_status     status;
        logic [9:0]  next_offset;
    } t_out_item;

    typedef enum logic [1:0] {
        JOB_STORE,
        JOB_DECODE,
        JOB_DROP
    } t_job_kind;

    typedef struct packed {
        t_job_kind         kind;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_job;

    typedef enum logic [3:0] {
        W_IDLE,
        W_RD_LEN,
        W_LEN_WAIT,
        W_PTR_WAIT,
        W_CHARS,
        W_DOT,
        W_EMIT_RD,
        W_EMIT_PUSH,
        W_ERROR
    } t_walk_state;

endpackage

`default_nettype wire

>>> rtl/dnd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module dnd_front #(
    parameter int MSG_BYTES = dnd_pkg::MSG_BYTES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    output logic                   o_full,
    input  wire dnd_pkg::t_in_item i_item,
    output logic                   o_job_valid,
    output dnd_pkg::t_job          o_job,
    input  wire logic              i_job_take
);

    localparam int Depth = dnd_pkg::JOBQ_DEPTH;
    localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW  = $clog2(Depth + 1);

    dnd_pkg::t_job r_q [Depth];
    logic [PtrW-1:0] r_wp, r_rp;
    logic [CntW-1:0] r_cnt;
    dnd_pkg::t_job   job_in;
    logic            do_wr, do_rd;

    // classify the beat
    always_comb begin
        job_in.addr = i_item.address;
        job_in.data = i_item.data_byte;
        if (i_item.cmd == dnd_pkg::CMD_DECODE) begin
            job_in.kind = dnd_pkg::JOB_DECODE;
        end else if (32'(i_item.address) < MSG_BYTES) begin
            job_in.kind = dnd_pkg::JOB_STORE;
        end else begin
            job_in.kind = dnd_pkg::JOB_DROP;
        end
    end

    assign o_full      = (r_cnt == CntW'(Depth));
    assign o_job_valid = (r_cnt != '0);
    assign o_job       = r_q[r_rp];
    assign do_wr       = i_push && !o_full;
    assign do_rd       = i_job_take && o_job_valid;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_q[r_wp] <= job_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= (r_wp == PtrW'(Depth - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_rd) begin
                r_rp <= (r_rp == PtrW'(Depth - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/dnd_res_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module dnd_res_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    output logic                    o_full,
    input  wire dnd_pkg::t_out_item i_item,
    output logic                    o_empty,
    output dnd_pkg::t_out_item      o_item,
    input  wire logic               i_pop
);

    localparam int Depth = dnd_pkg::RESQ_DEPTH;
    localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW  = $clog2(Depth + 1);

    dnd_pkg::t_out_item r_q [Depth];
    logic [PtrW-1:0] r_wp, r_rp;
    logic [CntW-1:0] r_cnt;
    logic            do_wr, do_rd;

    assign o_full  = (r_cnt == CntW'(Depth));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_q[r_rp];
    assign do_wr   = i_push && !o_full;
    assign do_rd   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_q[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= (r_wp == PtrW'(Depth - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_rd) begin
                r_rp <= (r_rp == PtrW'(Depth - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/dnd_walker.sv
`timescale 1ns / 1ps
`default_nettype none

module dnd_walker #(
    parameter int MSG_BYTES = dnd_pkg::MSG_BYTES_DEF,
    parameter int MAX_HOPS  = dnd_pkg::MAX_HOPS_DEF,
    parameter int MAX_TEXT  = dnd_pkg::MAX_TEXT_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_job_valid,
    input  wire dnd_pkg::t_job      i_job,
    output logic                    o_job_take,
    output logic                    o_res_push,
    output dnd_pkg::t_out_item      o_res_item,
    input  wire logic               i_res_full
);

    localparam int PosW     = dnd_pkg::POS_W;
    localparam int AddrW    = $clog2(MSG_BYTES);
    localparam int LoadW    = $clog2(MSG_BYTES + 1);
    localparam int HopW     = $clog2(MAX_HOPS + 1);
    localparam int LenW     = $clog2(MAX_TEXT + 1);
    localparam int TxtWords = (MAX_TEXT + 3) / 4;
    localparam int TxtW     = (TxtWords > 1) ? $clog2(TxtWords) : 1;

    logic [7:0]  r_msg_mem [MSG_BYTES];
    logic [31:0] r_txt_mem [TxtWords];
    logic [7:0]  r_rdata;
    logic [31:0] r_tdata;

    dnd_pkg::t_walk_state r_state, n_state;
    dnd_pkg::t_status     r_status, n_status;
    logic [LoadW-1:0] r_loaded, n_loaded;
    logic [PosW-1:0]  r_pos, n_pos;
    logic [HopW-1:0]  r_hops, n_hops;
    logic             r_jumped, n_jumped;
    logic [9:0]       r_next, n_next;
    logic [LenW-1:0]  r_len, n_len;
    logic [31:0]      r_word, n_word;
    logic [7:0]       r_rem, n_rem;
    logic [7:0]       r_rcv, n_rcv;
    logic             r_pend, n_pend;
    logic [5:0]       r_hi, n_hi;
    logic [LenW-1:0]  r_k, n_k;

    logic             mem_rd_en, mem_wr_en;
    logic [AddrW-1:0] mem_rd_addr, mem_wr_addr;
    logic [7:0]       mem_wr_data;
    logic             txt_rd_en, txt_wr_en;
    logic [TxtW-1:0]  txt_rd_addr, txt_wr_addr;
    logic [31:0]      txt_wr_data;
    logic             app_en;
    logic [7:0]       app_ch;

    logic [PosW-1:0]  loaded_ext, pos_p1, addr_ext, addr_p1;
    logic             in_range, in_range1, text_full;
    logic [LenW-1:0]  full_words;
    logic [1:0]       rem_chars;
    logic             last_full;

    assign loaded_ext   = PosW'(r_loaded);
    assign pos_p1       = r_pos + 1'b1;
    assign addr_ext     = PosW'(i_job.addr);
    assign addr_p1      = addr_ext + 1'b1;
    assign in_range     = (r_pos < loaded_ext);
    assign in_range1    = (pos_p1 < loaded_ext);
    assign text_full    = (r_len >= LenW'(MAX_TEXT));
    assign full_words   = r_len >> 2;
    assign rem_chars    = r_len[1:0];
    assign last_full    = (rem_chars == 2'd0) && (LenW'(r_k + 1'b1) == full_words);

    always_comb begin
        logic err;
        err = 1'b0;

        n_state  = r_state;
        n_status = r_status;
        n_loaded = r_loaded;
        n_pos    = r_pos;
        n_hops   = r_hops;
        n_jumped = r_jumped;
        n_next   = r_next;
        n_len    = r_len;
        n_word   = r_word;
        n_rem    = r_rem;
        n_rcv    = r_rcv;
        n_pend   = r_pend;
        n_hi     = r_hi;
        n_k      = r_k;

        o_job_take  = 1'b0;
        o_res_push  = 1'b0;
        o_res_item  = '0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = r_pos[AddrW-1:0];
        mem_wr_en   = 1'b0;
        mem_wr_addr = addr_ext[AddrW-1:0];
        mem_wr_data = i_job.data;
        txt_rd_en   = 1'b0;
        txt_rd_addr = TxtW'(r_k);
        txt_wr_en   = 1'b0;
        txt_wr_addr = TxtW'(r_len >> 2);
        txt_wr_data = '0;
        app_en      = 1'b0;
        app_ch      = dnd_pkg::DOT_CHAR;

        unique case (r_state)
            dnd_pkg::W_IDLE: begin
                if (i_job_valid) begin
                    o_job_take = 1'b1;
                    unique case (i_job.kind)
                        dnd_pkg::JOB_STORE: begin
                            mem_wr_en = 1'b1;
                            if (addr_p1 > loaded_ext) begin
                                n_loaded = LoadW'(addr_p1);
                            end
                        end
                        dnd_pkg::JOB_DECODE: begin
                            n_pos    = addr_ext;
                            n_hops   = '0;
                            n_jumped = 1'b0;
                            n_next   = '0;
                            n_len    = '0;
                            n_word   = '0;
                            n_state  = dnd_pkg::W_RD_LEN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            dnd_pkg::W_RD_LEN: begin
                if (!in_range) begin
                    n_status = dnd_pkg::ST_RANGE;
                    n_state  = dnd_pkg::W_ERROR;
                end else begin
                    mem_rd_en = 1'b1;
                    n_state   = dnd_pkg::W_LEN_WAIT;
                end
            end
            dnd_pkg::W_LEN_WAIT: begin
                if (r_rdata[7:6] == dnd_pkg::PTR_TAG) begin
                    if (!in_range1) begin
                        n_status = dnd_pkg::ST_RANGE;
                        n_state  = dnd_pkg::W_ERROR;
                    end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = pos_p1[AddrW-1:0];
                        n_hi        = r_rdata[5:0];
                        n_state     = dnd_pkg::W_PTR_WAIT;
                    end
                end else if (r_rdata == 8'd0) begin
                    if (!r_jumped) begin
                        n_next = 10'(pos_p1);
                    end
                    // root name gives a single dot
                    if (r_len == '0) begin
                        app_en = 1'b1;
                        app_ch = dnd_pkg::DOT_CHAR;
                    end
                    n_k     = '0;
                    n_state = dnd_pkg::W_EMIT_RD;
                end else begin
                    n_rem   = r_rdata;
                    n_rcv   = r_rdata;
                    n_pend  = 1'b0;
                    n_pos   = pos_p1;
                    n_state = dnd_pkg::W_CHARS;
                end
            end
            dnd_pkg::W_PTR_WAIT: begin
                if (!r_jumped) begin
                    n_next   = 10'(r_pos + 2'd2);
                    n_jumped = 1'b1;
                end
                if (r_hops == HopW'(MAX_HOPS)) begin
                    n_status = dnd_pkg::ST_HOPS;
                    n_state  = dnd_pkg::W_ERROR;
                end else begin
                    n_hops  = r_hops + 1'b1;
                    n_pos   = PosW'({r_hi, r_rdata});
                    n_state = dnd_pkg::W_RD_LEN;
                end
            end
            dnd_pkg::W_CHARS: begin
                if (r_pend) begin
                    if (text_full) begin
                        err      = 1'b1;
                        n_status = dnd_pkg::ST_LONG;
                        n_state  = dnd_pkg::W_ERROR;
                    end else begin
                        app_en = 1'b1;
                        app_ch = r_rdata;
                        n_rcv  = r_rcv - 1'b1;
                    end
                end
                if (!err) begin
                    if (r_rem != 8'd0) begin
                        if (!in_range) begin
                            err      = 1'b1;
                            n_status = dnd_pkg::ST_RANGE;
                            n_state  = dnd_pkg::W_ERROR;
                        end else begin
                            mem_rd_en = 1'b1;
                            n_pos     = pos_p1;
                            n_rem     = r_rem - 1'b1;
                            n_pend    = 1'b1;
                        end
                    end else begin
                        n_pend = 1'b0;
                    end
                end
                if (!err && r_pend && (r_rcv == 8'd1)) begin
                    n_state = dnd_pkg::W_DOT;
                end
            end
            dnd_pkg::W_DOT: begin
                if (text_full) begin
                    n_status = dnd_pkg::ST_LONG;
                    n_state  = dnd_pkg::W_ERROR;
                end else begin
                    app_en  = 1'b1;
                    app_ch  = dnd_pkg::DOT_CHAR;
                    n_state = dnd_pkg::W_RD_LEN;
                end
            end
            dnd_pkg::W_EMIT_RD: begin
                if (r_k < full_words) begin
                    txt_rd_en = 1'b1;
                    n_state   = dnd_pkg::W_EMIT_PUSH;
                end else if (!i_res_full) begin
                    // trailing partial word
                    o_res_push             = 1'b1;
                    o_res_item.text_chars  = r_word;
                    o_res_item.char_count  = {1'b0, rem_chars};
                    o_res_item.last        = 1'b1;
                    o_res_item.status      = dnd_pkg::ST_OK;
                    o_res_item.next_offset = r_next;
                    n_state                = dnd_pkg::W_IDLE;
                end
            end
            dnd_pkg::W_EMIT_PUSH: begin
                if (!i_res_full) begin
                    o_res_push             = 1'b1;
                    o_res_item.text_chars  = r_tdata;
                    o_res_item.char_count  = 3'd4;
                    o_res_item.last        = last_full;
                    o_res_item.status      = dnd_pkg::ST_OK;
                    o_res_item.next_offset = last_full ? r_next : 10'd0;
                    n_k                    = r_k + 1'b1;
                    n_state = last_full ? dnd_pkg::W_IDLE : dnd_pkg::W_EMIT_RD;
                end
            end
            dnd_pkg::W_ERROR: begin
                if (!i_res_full) begin
                    o_res_push        = 1'b1;
                    o_res_item.last   = 1'b1;
                    o_res_item.status = r_status;
                    n_state           = dnd_pkg::W_IDLE;
                end
            end
            default: begin
                n_state = dnd_pkg::W_IDLE;
            end
        endcase

        // pack one character into the text word
        if (app_en) begin
            n_len = r_len + 1'b1;
            unique case (r_len[1:0])
                2'd0: n_word = {r_word[31:8], app_ch};
                2'd1: n_word = {r_word[31:16], app_ch, r_word[7:0]};
                2'd2: n_word = {r_word[31:24], app_ch, r_word[15:0]};
                2'd3: begin
                    txt_wr_en   = 1'b1;
                    txt_wr_data = {app_ch, r_word[23:0]};
                    n_word      = '0;
                end
                default: n_word = r_word;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_wr_en) begin
            r_msg_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en) begin
            r_rdata <= r_msg_mem[mem_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (txt_wr_en) begin
            r_txt_mem[txt_wr_addr] <= txt_wr_data;
        end
        if (txt_rd_en) begin
            r_tdata <= r_txt_mem[txt_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dnd_pkg::W_IDLE;
            r_loaded <= '0;
        end else begin
            r_state  <= n_state;
            r_loaded <= n_loaded;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_pos    <= n_pos;
        r_hops   <= n_hops;
        r_jumped <= n_jumped;
        r_next   <= n_next;
        r_len    <= n_len;
        r_word   <= n_word;
        r_rem    <= n_rem;
        r_rcv    <= n_rcv;
        r_pend   <= n_pend;
        r_hi     <= n_hi;
        r_k      <= n_k;
    end

endmodule

`default_nettype wire

>>> rtl/dns_name_decompressor_unit.sv
// dns name decompressor: message bytes and decode requests enter on one queue-like
// channel (push/full, payload i_req); results leave on another (empty/pop, o_res).
// a store beat (cmd 0) writes one message byte; one at or past MSG_BYTES is dropped.
// a decode beat (cmd 1) walks the name from the given offset and returns the text
// packed four characters per beat, last set on the final beat together with the
// offset just after the name; an error gives one beat with only last and status.
// the walk reads each length byte, then the label characters one by one and adds a
// dot per label, and reads both bytes of each pointer, all through the single read
// port of the message memory; the text is then drained from a word buffer, each
// full result beat read from the buffer before it is pushed, and a trailing
// partial beat pushed straight from the packing word; one decode at a time.
// a 4-deep request queue lets requests be accepted while a walk is running and a
// 2-deep result queue holds finished beats when the receiver stalls; a stalled
// receiver only pauses the drain. reset clears both queues, the walker state and
// the loaded length; message memory contents are kept and need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module dns_name_decompressor_unit #(
    parameter int MSG_BYTES = dnd_pkg::MSG_BYTES_DEF,
    parameter int MAX_HOPS  = dnd_pkg::MAX_HOPS_DEF,
    parameter int MAX_TEXT  = dnd_pkg::MAX_TEXT_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire dnd_pkg::t_in_item  i_req,
    output logic                    empty,
    input  wire logic               pop,
    output dnd_pkg::t_out_item      o_res
);

    logic               job_valid, job_take;
    dnd_pkg::t_job      job;
    logic               res_push, res_full;
    dnd_pkg::t_out_item res_item;

    dnd_front #(
        .MSG_BYTES (MSG_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_req),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_take  (job_take)
    );

    dnd_walker #(
        .MSG_BYTES (MSG_BYTES),
        .MAX_HOPS  (MAX_HOPS),
        .MAX_TEXT  (MAX_TEXT)
    ) u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_take  (job_take),
        .o_res_push  (res_push),
        .o_res_item  (res_item),
        .i_res_full  (res_full)
    );

    dnd_res_queue u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .o_full  (res_full),
        .i_item  (res_item),
        .o_empty (empty),
        .o_item  (o_res),
        .i_pop   (pop)
    );

endmodule

`default_nettype wire
